[rtl/core/sorted_term_list_core_assert.svh]
// ----------------------------------------------------------------------------
// Sorted term list assertion macros
// Shared assertion forms for the sorted term list core.
// ----------------------------------------------------------------------------
`ifndef SORTED_TERM_LIST_CORE_ASSERT_SVH
`define SORTED_TERM_LIST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/stl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted term list package
// Request and response types, cell link types and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // Response status codes.
   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   typedef struct packed {
      logic [1:0]          kind;
      logic signed [31:0]  coefficient;
      logic signed [15:0]  exponent;
      logic [3:0]          index;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic signed [31:0]  read_coefficient;
      logic signed [15:0]  read_exponent;
      logic [4:0]          term_total;
   } rsp_type;

   // One stored term.
   typedef struct packed {
      logic signed [31:0]  coefficient;
      logic signed [15:0]  exponent;
   } entry_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic                insert_en;
      logic                delete_en;
      logic signed [31:0]  coefficient;
      logic signed [15:0]  exponent;
      logic [3:0]          index;
   } cell_cmd_type;

   // Carry chain passed from each cell to its right neighbor.
   typedef struct packed {
      logic                greater;
      logic                found;
      logic                tail_found;
      logic                rd_hit;
      entry_type           rd_entry;
   } link_type;

endpackage

`default_nettype wire

[rtl/core/stl_cell.sv]
// ----------------------------------------------------------------------------
// Sorted term list cell
// Holds one term and decides each cycle whether to keep it, load the new
// term, take the left neighbor (insert) or take the right neighbor (delete).
// ----------------------------------------------------------------------------
`default_nettype none

module stl_cell #(
   parameter int POS   = 0,
   parameter int CNT_W = 5
) (
   input  wire                        clock,
   input  wire stl_pkg::cell_cmd_type cmd,
   input  wire                        tail_sel,
   input  wire [CNT_W-1:0]            count,
   input  wire stl_pkg::entry_type    left_entry,
   input  wire stl_pkg::entry_type    right_entry,
   input  wire stl_pkg::link_type     link_in,
   output stl_pkg::link_type          link_out,
   output stl_pkg::entry_type         entry_out
);

   stl_pkg::entry_type entry_ff;
   stl_pkg::entry_type entry_in;
   logic               occupied;
   logic               is_tail;
   logic               greater;
   logic               match;
   logic               hit;

   // Position status relative to the current fill level.
   assign occupied = int'(count) > POS;
   assign is_tail  = int'(count) == POS + 1;
   assign greater  = occupied && ($signed(entry_ff.exponent) > $signed(cmd.exponent));
   assign match    = occupied && (entry_ff.exponent == cmd.exponent);
   assign hit      = occupied && (int'(cmd.index) == POS);

   // Carry chain toward the tail.
   always_comb begin
      link_out.greater    = link_in.greater && greater;
      link_out.found      = link_in.found || match;
      link_out.tail_found = link_in.tail_found || (match && is_tail);
      link_out.rd_hit     = link_in.rd_hit || hit;
      link_out.rd_entry   = hit ? entry_ff : link_in.rd_entry;
   end

   // Next content of this cell.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en) begin
         if (link_in.greater && greater) begin
            entry_in = entry_ff;
         end else if (link_in.greater) begin
            entry_in.coefficient = cmd.coefficient;
            entry_in.exponent    = cmd.exponent;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.delete_en && !tail_sel && (link_in.found || match)) begin
         entry_in = right_entry;
      end
   end

   // Term payload needs no reset: only positions below the count are read.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

[rtl/core/sorted_term_list_core.sv]
// A response strobes on rsp_valid in the cycle after its request is taken.
// Throughput: one request per cycle; busy stays low, as each request settles in
// a single pass through the row of cells and the count register.
// Reset clears the term count and the response strobe; stored terms are not
// cleared and are only read below the count.
// ----------------------------------------------------------------------------
// Sorted term list core
// Keeps polynomial terms in descending exponent order in a row of cells and
// serves insert, delete and read requests.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_term_list_core_assert.svh"

module sorted_term_list_core #(
   parameter int MAX_TERMS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire stl_pkg::req_type req_item,
   output logic                 rsp_valid,
   output stl_pkg::rsp_type     rsp_item
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   logic                    accept;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   stl_pkg::rsp_type        rsp_item_ff;
   stl_pkg::rsp_type        rsp_item_in;
   logic                    full;
   logic                    empty;
   logic                    tail_any;
   logic                    tail_sel;
   stl_pkg::cell_cmd_type   cmd;
   stl_pkg::entry_type      new_entry;
   stl_pkg::link_type       links [0:MAX_TERMS];
   stl_pkg::entry_type      entries [0:MAX_TERMS-1];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = count_ff == CNT_W'(MAX_TERMS);
   assign empty  = count_ff == '0;

   assign new_entry.coefficient = req_item.coefficient;
   assign new_entry.exponent    = req_item.exponent;

   // Chain head: the new term goes first unless a larger exponent is ahead.
   always_comb begin
      links[0].greater    = 1'b1;
      links[0].found      = 1'b0;
      links[0].tail_found = 1'b0;
      links[0].rd_hit     = 1'b0;
      links[0].rd_entry   = '0;
   end

   // A tail match wins over an inner match only when the head does not match.
   assign tail_any = links[MAX_TERMS].tail_found;
   assign tail_sel = tail_any && !links[1].found;

   // Command broadcast to all cells.
   always_comb begin
      cmd.insert_en   = accept && (req_item.kind == stl_pkg::KIND_INSERT) && !full;
      cmd.delete_en   = accept && (req_item.kind == stl_pkg::KIND_DELETE);
      cmd.coefficient = req_item.coefficient;
      cmd.exponent    = req_item.exponent;
      cmd.index       = req_item.index;
   end

   // Row of cells.
   for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
      stl_pkg::entry_type left_w;
      stl_pkg::entry_type right_w;

      if (i == 0) begin : g_first
         assign left_w = new_entry;
      end else begin : g_inner_l
         assign left_w = entries[i-1];
      end

      if (i == MAX_TERMS - 1) begin : g_last
         assign right_w = entries[i];
      end else begin : g_inner_r
         assign right_w = entries[i+1];
      end

      stl_cell #(
         .POS   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .tail_sel    (tail_sel),
         .count       (count_ff),
         .left_entry  (left_w),
         .right_entry (right_w),
         .link_in     (links[i]),
         .link_out    (links[i+1]),
         .entry_out   (entries[i])
      );
   end

   // Count update and response formation.
   always_comb begin
      count_in    = count_ff;
      rsp_item_in = '0;
      case (req_item.kind)
         stl_pkg::KIND_INSERT: begin
            if (full) begin
               rsp_item_in.status = stl_pkg::ST_FULL;
            end else begin
               rsp_item_in.status = stl_pkg::ST_DONE;
               count_in           = count_ff + 1'b1;
            end
         end
         stl_pkg::KIND_DELETE: begin
            if (empty) begin
               rsp_item_in.status = stl_pkg::ST_EMPTY;
            end else if (links[MAX_TERMS].found) begin
               rsp_item_in.status = stl_pkg::ST_DONE;
               count_in           = count_ff - 1'b1;
            end else begin
               rsp_item_in.status = stl_pkg::ST_NOT_FOUND;
            end
         end
         stl_pkg::KIND_READ: begin
            if (links[MAX_TERMS].rd_hit) begin
               rsp_item_in.status           = stl_pkg::ST_DONE;
               rsp_item_in.read_coefficient = links[MAX_TERMS].rd_entry.coefficient;
               rsp_item_in.read_exponent    = links[MAX_TERMS].rd_entry.exponent;
            end else begin
               rsp_item_in.status = stl_pkg::ST_RANGE;
            end
         end
         default: begin
            rsp_item_in.status = stl_pkg::ST_DONE;
         end
      endcase
      rsp_item_in.term_total = 5'(count_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Checks on the response strobe and the fill count.
   `STL_ASSERT_NEXT(a_rsp_follows_req, clock, reset, accept, rsp_valid, "response missing after request")
   `STL_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !accept, !rsp_valid, "response without request")
   `STL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_TERMS), "count overflow")
   `STL_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.insert_en, count_ff == $past(count_ff) + 1'b1, "insert did not grow count")
   `STL_ASSERT_NOW(a_full_status, clock, reset, rsp_valid && (rsp_item.status == stl_pkg::ST_FULL), count_ff == CNT_W'(MAX_TERMS), "full status with free room")

endmodule

`default_nettype wire

[tb/sorted_term_list_core_tb.sv]
// ----------------------------------------------------------------------------
// Sorted term list core testbench
// Sends insert, delete and read requests to the term list core. A shadow copy
// of the sorted table predicts every response, and each response is compared
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module sorted_term_list_core_tb;

   localparam int         MAX_TERMS      = 16;
   localparam int         STIM_TOTAL     = 545;
   localparam int         QUIET_TAIL     = 80;
   localparam int         WATCHDOG_LIMIT = 200;
   localparam int         REPORT_LIMIT   = 10;
   localparam logic [1:0] KIND_UNUSED    = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   stl_pkg::req_type req_item = '0;
   logic             rsp_valid;
   stl_pkg::rsp_type rsp_item;

   // Requests waiting to be driven, and predicted responses waiting to arrive.
   stl_pkg::req_type pending_reqs[$];
   stl_pkg::rsp_type queued_reports[$];

   // Shadow copy of the sorted table, updated at each accepted request.
   logic signed [31:0] shadow_coef [MAX_TERMS];
   logic signed [15:0] shadow_expo [MAX_TERMS];
   int                 shadow_count = 0;

   // Exponents the stimulus has put in the table so far, in any order.
   logic signed [15:0] stim_expos[$];
   int                 stim_count = 0;

   logic req_taken    = 1'b0;
   int   idle_left    = 0;
   int   quiet_cycles = 0;
   int   fault_count  = 0;

   always #4 clock = ~clock;

   sorted_term_list_core #(
      .MAX_TERMS(MAX_TERMS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // Apply one request to the shadow table and return the response it gives.
   function automatic stl_pkg::rsp_type apply_to_shadow(stl_pkg::req_type req);
      stl_pkg::rsp_type   rsp;
      logic signed [15:0] expo;
      int                 pos;
      int                 hit;
      rsp = '0;
      rsp.status = stl_pkg::ST_DONE;
      expo = req.exponent;
      case (req.kind)
         stl_pkg::KIND_INSERT: begin
            if (shadow_count >= MAX_TERMS) begin
               rsp.status = stl_pkg::ST_FULL;
            end else begin
               // The new term goes ahead of every term with an exponent not above it.
               pos = 0;
               while (pos < shadow_count && shadow_expo[pos] > expo) pos++;
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_coef[i] = shadow_coef[i - 1];
                  shadow_expo[i] = shadow_expo[i - 1];
               end
               shadow_coef[pos] = req.coefficient;
               shadow_expo[pos] = expo;
               shadow_count++;
            end
         end
         stl_pkg::KIND_DELETE: begin
            // Head first, then tail, then the first match from the front.
            hit = -1;
            if (shadow_count == 0) begin
               rsp.status = stl_pkg::ST_EMPTY;
            end else if (shadow_expo[0] == expo) begin
               hit = 0;
            end else if (shadow_expo[shadow_count - 1] == expo) begin
               hit = shadow_count - 1;
            end else begin
               for (int i = 1; i + 1 < shadow_count; i++) begin
                  if (hit < 0 && shadow_expo[i] == expo) hit = i;
               end
               if (hit < 0) rsp.status = stl_pkg::ST_NOT_FOUND;
            end
            if (hit >= 0) begin
               for (int i = hit; i + 1 < shadow_count; i++) begin
                  shadow_coef[i] = shadow_coef[i + 1];
                  shadow_expo[i] = shadow_expo[i + 1];
               end
               shadow_count--;
            end
         end
         stl_pkg::KIND_READ: begin
            if (int'(req.index) < shadow_count) begin
               rsp.read_coefficient = shadow_coef[req.index];
               rsp.read_exponent    = shadow_expo[req.index];
            end else begin
               rsp.status = stl_pkg::ST_RANGE;
            end
         end
         default: begin
            // The unused kind leaves the table alone.
         end
      endcase
      rsp.term_total = 5'(shadow_count);
      return rsp;
   endfunction

   // Queue one request and track which exponents it leaves in the table.
   task automatic queue_request(logic [1:0] kind, logic signed [31:0] coef,
                                logic signed [15:0] expo, logic [3:0] idx);
      stl_pkg::req_type req;
      int               found;
      req.kind        = kind;
      req.coefficient = coef;
      req.exponent    = expo;
      req.index       = idx;
      pending_reqs.push_back(req);
      if (kind != KIND_UNUSED) stim_count++;
      if (kind == stl_pkg::KIND_INSERT && stim_expos.size() < MAX_TERMS) begin
         stim_expos.push_back(expo);
      end else if (kind == stl_pkg::KIND_DELETE) begin
         found = -1;
         foreach (stim_expos[i]) begin
            if (found < 0 && stim_expos[i] == expo) found = i;
         end
         if (found >= 0) stim_expos.delete(found);
      end
   endtask

   // Mostly small exponents so that equal ones meet, sometimes any value,
   // sometimes one already stored.
   function automatic logic signed [15:0] pick_exponent();
      logic [1:0] pick;
      pick = 2'($urandom_range(0, 3));
      if (pick == 2'd3 && stim_expos.size() != 0)
         return stim_expos[$urandom_range(0, stim_expos.size() - 1)];
      if (pick == 2'd2)
         return 16'($urandom);
      return 16'($signed($urandom_range(0, 8)) - 4);
   endfunction

   // Driver: presents queued requests and idles in random bursts.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // Hold the request until it is taken.
      end else if (idle_left != 0) begin
         start     <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (pending_reqs.size() != 0) begin
         if (pending_reqs.size() > QUIET_TAIL && (pending_reqs.size() / 64) % 2 == 0 &&
             $urandom_range(0, 5) == 0) begin
            start     <= 1'b0;
            idle_left <= $urandom_range(0, 7);
         end else begin
            start    <= 1'b1;
            req_item <= pending_reqs.pop_front();
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predicts each accepted request and checks each response.
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= start && !busy;

         if (rsp_valid) begin
            if (queued_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("Unexpected response: status %0d coef %0d expo %0d total %0d",
                           rsp_item.status, rsp_item.read_coefficient,
                           rsp_item.read_exponent, rsp_item.term_total);
            end else begin
               automatic stl_pkg::rsp_type want = queued_reports.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.read_coefficient !== want.read_coefficient ||
                   rsp_item.read_exponent !== want.read_exponent ||
                   rsp_item.term_total !== want.term_total) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("Mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              want.status, want.read_coefficient, want.read_exponent,
                              want.term_total,
                              rsp_item.status, rsp_item.read_coefficient,
                              rsp_item.read_exponent, rsp_item.term_total);
               end
            end
         end

         if (start && !busy) queued_reports.push_back(apply_to_shadow(req_item));

         // Watchdog over cycles in which no request and no response moves.
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int scenario;
      int burst;
      int pick;

      // Directed part: empty table, extremes, equal exponents and each delete path.
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd0);
      queue_request(stl_pkg::KIND_DELETE, '0, 16'sd5, '0);
      queue_request(KIND_UNUSED, '0, '0, '0);
      queue_request(stl_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF, '0);
      queue_request(stl_pkg::KIND_INSERT, 32'sh8000_0000, 16'sh8000, '0);
      queue_request(stl_pkg::KIND_INSERT, '0, '0, '0);
      queue_request(stl_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, '0);
      queue_request(stl_pkg::KIND_INSERT, 32'sd5, '0, '0);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd0);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd1);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd2);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd5);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd15);
      queue_request(stl_pkg::KIND_DELETE, '0, 16'sd123, '0);
      // A second lowest exponent lands ahead of the first; the tail one goes.
      queue_request(stl_pkg::KIND_INSERT, 32'h5555_5555, 16'sh8000, '0);
      queue_request(stl_pkg::KIND_DELETE, '0, 16'sh8000, '0);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd4);
      queue_request(stl_pkg::KIND_DELETE, '0, '0, '0);
      queue_request(stl_pkg::KIND_DELETE, '0, 16'sh7FFF, '0);
      queue_request(stl_pkg::KIND_DELETE, '0, 16'sh8000, '0);
      queue_request(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
      queue_request(stl_pkg::KIND_READ, '0, '0, 4'd0);

      // Random part: fill runs, drain runs and mixed single requests.
      while (stim_count < STIM_TOTAL) begin
         scenario = $urandom_range(0, 9);
         if (scenario <= 2) begin
            burst = $urandom_range(3, 18);
            repeat (burst) begin
               if ($urandom_range(0, 4) == 0)
                  queue_request(stl_pkg::KIND_READ, 32'($urandom), 16'($urandom),
                                4'($urandom_range(0, 15)));
               else
                  queue_request(stl_pkg::KIND_INSERT, 32'($urandom), pick_exponent(),
                                4'($urandom));
            end
         end else if (scenario <= 4) begin
            burst = $urandom_range(3, 16);
            repeat (burst) begin
               pick = $urandom_range(0, 9);
               if (pick <= 1)
                  queue_request(stl_pkg::KIND_READ, 32'($urandom), 16'($urandom),
                                4'($urandom_range(0, 15)));
               else if (pick <= 7 && stim_expos.size() != 0)
                  queue_request(stl_pkg::KIND_DELETE, 32'($urandom),
                                stim_expos[$urandom_range(0, stim_expos.size() - 1)],
                                4'($urandom));
               else
                  queue_request(stl_pkg::KIND_DELETE, 32'($urandom), pick_exponent(),
                                4'($urandom));
            end
         end else begin
            pick = $urandom_range(0, 9);
            if (pick <= 3)
               queue_request(stl_pkg::KIND_INSERT, 32'($urandom), pick_exponent(),
                             4'($urandom));
            else if (pick <= 6)
               queue_request(stl_pkg::KIND_DELETE, 32'($urandom), pick_exponent(),
                             4'($urandom));
            else if (pick <= 8)
               queue_request(stl_pkg::KIND_READ, 32'($urandom), 16'($urandom),
                             4'($urandom_range(0, 15)));
            else
               queue_request(KIND_UNUSED, 32'($urandom), 16'($urandom), 4'($urandom));
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every response to arrive.
      while (pending_reqs.size() != 0 || start || queued_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);

      if (queued_reports.size() != 0) fault_count++;
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
